@@ sv/assert_macros.svh @@
// assertion helpers used by the tokenizer unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define GLMT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GLMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/glmt_pkg.sv @@
// ----------------------------------------------------------------------------
// glmt_pkg
// shared constants, codes and types of the longest-match tokenizer
// ----------------------------------------------------------------------------
package glmt_pkg;

    localparam int MAX_TOKEN_BYTES = 8;
    localparam int VOCAB_ENTRIES   = 256;
    localparam int MAX_RESULTS     = 8;
    localparam int RW              = $clog2(MAX_RESULTS + 1);

    // request actions
    localparam logic [1:0] ACT_VOCAB_BYTE  = 2'd0;
    localparam logic [1:0] ACT_EMPTY_ENTRY = 2'd1;
    localparam logic [1:0] ACT_TEXT_BYTE   = 2'd2;
    localparam logic [1:0] ACT_CLEAR       = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_TOKEN  = 2'd0;
    localparam logic [1:0] KIND_SKIP   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    typedef logic [7:0] t_byte;

    // per-cell control
    typedef struct packed {
        logic load;
        logic shift;
        logic care;
    } t_cell_ctl;

endpackage

@@ sv/glmt_ifs.sv @@
// ----------------------------------------------------------------------------
// glmt request and result channels
// valid/ready channels carrying the tokenizer payloads
// ----------------------------------------------------------------------------
interface glmt_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] byte_value;
    logic       end_flag;

    modport source (output valid, action, byte_value, end_flag, input ready);
    modport sink   (input valid, action, byte_value, end_flag, output ready);
endinterface

interface glmt_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] token_id;
    logic [7:0] skipped_byte;
    logic       last_of_run;

    modport source (output valid, kind, token_id, skipped_byte, last_of_run, input ready);
    modport sink   (input valid, kind, token_id, skipped_byte, last_of_run, output ready);
endinterface

@@ sv/glmt_cell.sv @@
// ----------------------------------------------------------------------------
// glmt_cell
// one text window byte: load, shift from neighbor, prefix compare
// ----------------------------------------------------------------------------
module glmt_cell (
    input  logic                 i_clk,
    input  glmt_pkg::t_cell_ctl  i_ctl,
    input  glmt_pkg::t_byte      i_load_byte,
    input  glmt_pkg::t_byte      i_nbr_byte,
    input  glmt_pkg::t_byte      i_entry_byte,
    input  logic                 i_match,
    output glmt_pkg::t_byte      o_byte,
    output logic                 o_match
);
    import glmt_pkg::*;

    t_byte r_byte;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte <= i_nbr_byte;
        end else if (i_ctl.load) begin
            r_byte <= i_load_byte;
        end
    end

    assign o_byte  = r_byte;
    assign o_match = i_match & (~i_ctl.care | (r_byte == i_entry_byte));

endmodule

@@ sv/greedy_longest_match_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// greedy_longest_match_tokenizer_unit
// greedy longest-match tokenizer over a loadable vocabulary
// ----------------------------------------------------------------------------
// i_req carries one request: a vocabulary byte, an empty entry, a text byte
// or a clear. o_rsp carries results (token id, skipped byte or rejected
// entry), last_of_run marking the final result of a request.
// Vocabulary requests and clears are handled on acceptance; a rejected entry
// adds one result. A text request runs up to eight match decisions after a
// check step. Each decision sweeps the vocabulary memory one entry per cycle,
// then a decide step forms a result from the best candidate, an emit step
// hands it to the output register and a drop step removes the used bytes.
// The window sits in a row of byte cells; drops shift it one cell a cycle.
// i_req.ready is high only while no request is being worked on.
// Reset clears the vocabulary count, the partial entry and the window; the
// vocabulary memory itself is not cleared, only entries below the count are
// ever read. A stalled receiver holds the result register; the sequencer
// goes on with the next decision and waits before handing over its result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module greedy_longest_match_tokenizer_unit #(
    parameter int MAX_TOKEN_BYTES = glmt_pkg::MAX_TOKEN_BYTES,
    parameter int VOCAB_ENTRIES   = glmt_pkg::VOCAB_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    glmt_req_if.sink    i_req,
    glmt_rsp_if.source  o_rsp
);
    import glmt_pkg::*;

    localparam int LW = $clog2(MAX_TOKEN_BYTES + 1);
    localparam int IW = (VOCAB_ENTRIES > 1) ? $clog2(VOCAB_ENTRIES) : 1;
    localparam int CW = $clog2(VOCAB_ENTRIES + 1);
    localparam int DW = MAX_TOKEN_BYTES * 8;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;
    localparam logic [2:0] ST_DROP   = 3'd5;

    logic [2:0]    r_state;
    logic [CW-1:0] r_count;
    logic [LW-1:0] r_longest;
    t_byte         r_build [MAX_TOKEN_BYTES];
    logic [LW-1:0] r_blen;
    logic          r_ovf;
    logic [LW-1:0] r_fill;
    logic          r_end;
    logic [RW-1:0] r_n;
    logic [CW-1:0] r_scan;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic [LW+DW-1:0] r_rd_data;
    logic [LW-1:0] r_best_len;
    logic [IW-1:0] r_best_id;
    logic [LW-1:0] r_drop;
    logic          r_more;
    logic [1:0]    r_pend_kind;
    t_byte         r_pend_id;
    t_byte         r_pend_skip;
    logic          r_pend_last;
    logic          r_out_valid;
    logic [1:0]    r_out_kind;
    t_byte         r_out_id;
    t_byte         r_out_skip;
    logic          r_out_last;

    // vocabulary memory: {length, bytes}
    logic [LW+DW-1:0] mem [VOCAB_ENTRIES];

    logic             w_acc;
    logic             w_app;
    logic             w_full;
    logic             w_reject;
    logic [DW-1:0]    w_wbytes;
    logic [LW-1:0]    w_wlen;
    logic             w_we;
    logic [LW+DW-1:0] w_wdata;
    logic             w_rd_en;
    logic [DW-1:0]    w_rd_bytes;
    logic [LW-1:0]    w_rd_len;
    t_cell_ctl        w_ctl [MAX_TOKEN_BYTES];
    t_byte            w_win [MAX_TOKEN_BYTES+1];
    logic [MAX_TOKEN_BYTES:0] w_match;
    logic             w_hit;
    logic             w_has;
    logic [LW-1:0]    w_dlen;
    logic [LW-1:0]    w_nfill;
    logic [RW-1:0]    w_n1;
    logic             w_more;
    logic [IW+7:0]    w_id_ext;
    logic             w_slot;
    logic             w_text_load;

    assign w_acc         = i_req.valid && i_req.ready;
    assign i_req.ready   = (r_state == ST_IDLE);

    // partial entry with this byte appended
    assign w_app  = (r_blen < LW'(MAX_TOKEN_BYTES));
    assign w_full = (r_count >= CW'(VOCAB_ENTRIES));
    assign w_wlen = w_app ? (r_blen + LW'(1)) : r_blen;
    always_comb begin
        for (int k = 0; k < MAX_TOKEN_BYTES; k++) begin
            w_wbytes[8*k +: 8] = (w_app && (r_blen == LW'(k))) ? i_req.byte_value
                                                                : r_build[k];
        end
    end
    assign w_reject = r_ovf || !w_app || w_full;

    // memory write on a completed entry or an empty entry
    always_comb begin
        w_we    = 1'b0;
        w_wdata = {w_wlen, w_wbytes};
        if (w_acc && (i_req.action == ACT_VOCAB_BYTE) && i_req.end_flag && !w_reject) begin
            w_we = 1'b1;
        end else if (w_acc && (i_req.action == ACT_EMPTY_ENTRY) && !w_full) begin
            w_we    = 1'b1;
            w_wdata = {LW'(0), w_wbytes};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_count[IW-1:0]] <= w_wdata;
        end
    end

    assign w_rd_en = (r_state == ST_SCAN) && (r_scan < r_count);

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= mem[r_scan[IW-1:0]];
            r_rd_idx  <= r_scan[IW-1:0];
        end
    end

    assign w_rd_bytes = r_rd_data[DW-1:0];
    assign w_rd_len   = r_rd_data[LW+DW-1:DW];

    // window cell chain
    assign w_text_load = w_acc && (i_req.action == ACT_TEXT_BYTE) &&
                         (r_fill < LW'(MAX_TOKEN_BYTES));
    assign w_win[MAX_TOKEN_BYTES] = '0;
    assign w_match[0] = 1'b1;

    for (genvar g = 0; g < MAX_TOKEN_BYTES; g++) begin : g_cell
        always_comb begin
            w_ctl[g].load  = w_text_load && (r_fill == LW'(g));
            w_ctl[g].shift = (r_state == ST_DROP);
            w_ctl[g].care  = (LW'(g) < w_rd_len);
        end

        glmt_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl[g]),
            .i_load_byte  (i_req.byte_value),
            .i_nbr_byte   (w_win[g+1]),
            .i_entry_byte (w_rd_bytes[8*g +: 8]),
            .i_match      (w_match[g]),
            .o_byte       (w_win[g]),
            .o_match      (w_match[g+1])
        );
    end

    // candidate: prefix match, nonzero length, fits the window; ties go high
    assign w_hit = r_rd_vld && w_match[MAX_TOKEN_BYTES] && (w_rd_len != '0) &&
                   (w_rd_len <= r_fill) && (w_rd_len >= r_best_len);

    // decision
    assign w_has    = (r_best_len != '0);
    assign w_dlen   = w_has ? r_best_len : LW'(1);
    assign w_nfill  = r_fill - w_dlen;
    assign w_n1     = r_n + RW'(1);
    assign w_more   = (w_nfill != '0) && (w_n1 < RW'(MAX_RESULTS)) &&
                      (r_end || (w_nfill >= r_longest));
    assign w_id_ext = {8'h00, r_best_id};

    assign w_slot = !r_out_valid || o_rsp.ready;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_longest   <= '0;
            r_blen      <= '0;
            r_ovf       <= 1'b0;
            r_fill      <= '0;
            r_n         <= '0;
            r_scan      <= '0;
            r_rd_vld    <= 1'b0;
            r_drop      <= '0;
            r_more      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // output register: loaded from the emit step, freed by the receiver
            if ((r_state == ST_EMIT) && w_slot) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        unique case (i_req.action)
                            ACT_VOCAB_BYTE: begin
                                if (!i_req.end_flag) begin
                                    r_blen <= w_wlen;
                                    r_ovf  <= r_ovf | ~w_app;
                                end else begin
                                    r_blen <= '0;
                                    r_ovf  <= 1'b0;
                                    if (w_reject) begin
                                        r_drop  <= '0;
                                        r_state <= ST_EMIT;
                                    end else begin
                                        r_count <= r_count + CW'(1);
                                        if (w_wlen > r_longest) begin
                                            r_longest <= w_wlen;
                                        end
                                    end
                                end
                            end
                            ACT_EMPTY_ENTRY: begin
                                r_blen <= '0;
                                r_ovf  <= 1'b0;
                                if (w_full) begin
                                    r_drop  <= '0;
                                    r_state <= ST_EMIT;
                                end else begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            ACT_TEXT_BYTE: begin
                                if (w_text_load) begin
                                    r_fill <= r_fill + LW'(1);
                                end
                                r_n     <= '0;
                                r_state <= ST_CHECK;
                            end
                            default: begin
                                r_count   <= '0;
                                r_longest <= '0;
                                r_blen    <= '0;
                                r_ovf     <= 1'b0;
                                r_fill    <= '0;
                            end
                        endcase
                    end
                end
                ST_CHECK: begin
                    if ((r_fill != '0) && (r_end || (r_fill >= r_longest))) begin
                        r_scan   <= '0;
                        r_rd_vld <= 1'b0;
                        r_state  <= ST_SCAN;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_SCAN: begin
                    r_rd_vld <= w_rd_en;
                    if (w_rd_en) begin
                        r_scan <= r_scan + CW'(1);
                    end else if (!r_rd_vld) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    r_n     <= w_n1;
                    r_drop  <= w_dlen;
                    r_more  <= w_more;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (w_slot) begin
                        r_state <= (r_drop != '0) ? ST_DROP : ST_IDLE;
                    end
                end
                ST_DROP: begin
                    r_fill <= r_fill - LW'(1);
                    r_drop <= r_drop - LW'(1);
                    if (r_drop == LW'(1)) begin
                        if (r_more) begin
                            r_scan   <= '0;
                            r_rd_vld <= 1'b0;
                            r_state  <= ST_SCAN;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // payload: partial entry, best candidate, pending and output result
    always_ff @(posedge i_clk) begin
        if (w_acc && (i_req.action == ACT_VOCAB_BYTE) && w_app) begin
            for (int k = 0; k < MAX_TOKEN_BYTES; k++) begin
                r_build[k] <= w_wbytes[8*k +: 8];
            end
        end
        if (w_acc && (i_req.action == ACT_TEXT_BYTE)) begin
            r_end <= i_req.end_flag;
        end
        if ((r_state == ST_CHECK) || ((r_state == ST_DROP) && (r_drop == LW'(1)))) begin
            r_best_len <= '0;
            r_best_id  <= '0;
        end else if (w_hit) begin
            r_best_len <= w_rd_len;
            r_best_id  <= r_rd_idx;
        end
        if (r_state == ST_IDLE) begin
            r_pend_kind <= KIND_REJECT;
            r_pend_id   <= '0;
            r_pend_skip <= '0;
            r_pend_last <= 1'b1;
        end else if (r_state == ST_DECIDE) begin
            r_pend_kind <= w_has ? KIND_TOKEN : KIND_SKIP;
            r_pend_id   <= w_has ? w_id_ext[7:0] : 8'h00;
            r_pend_skip <= w_has ? 8'h00 : w_win[0];
            r_pend_last <= !w_more;
        end
        if ((r_state == ST_EMIT) && w_slot) begin
            r_out_kind <= r_pend_kind;
            r_out_id   <= r_pend_id;
            r_out_skip <= r_pend_skip;
            r_out_last <= r_pend_last;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.kind         = r_out_kind;
    assign o_rsp.token_id     = r_out_id;
    assign o_rsp.skipped_byte = r_out_skip;
    assign o_rsp.last_of_run  = r_out_last;

    `GLMT_ASSERT_NOW(a_best_fits, (r_state == ST_DECIDE), (r_best_len <= r_fill), "match longer than window")
    `GLMT_ASSERT_NEXT(a_drop_done, ((r_state == ST_DROP) && (r_drop == LW'(1)) && !r_more), (r_state == ST_IDLE), "run did not end after last drop")
    `GLMT_ASSERT_NOW(a_run_bound, (r_state == ST_EMIT), (r_n <= RW'(MAX_RESULTS)), "too many results in one run")

endmodule
